// ===== sv/tsta_pkg.sv =====
// Shared types, constants and helper functions for the scaled texture tile addresser.
// Used by tsta_cfg, tsta_div and scaled_texture_tile_addresser; depends on nothing.
`timescale 1ns / 1ps

package tsta_pkg;

   // Field widths.
   localparam int SRC_DIM_W   = 12;
   localparam int DST_W_W     = 9;
   localparam int DST_H_W     = 8;
   localparam int PIX_W       = 32;
   localparam int SRC_OFF_W   = 24;
   localparam int TEX_OFF_W   = 17;
   localparam int TEX_SHIFT_W = 4;

   // Register bounds; writes are clamped into [1, max].
   localparam logic [SRC_DIM_W-1:0] MAX_SRC_DIM = SRC_DIM_W'(4000);
   localparam logic [DST_W_W-1:0]   MAX_DST_W   = DST_W_W'(300);
   localparam logic [DST_H_W-1:0]   MAX_DST_H   = DST_H_W'(208);

   // Register indexes.
   localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
   localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
   localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

   // Live configuration as seen by the datapath.
   typedef struct packed {
      logic [SRC_DIM_W-1:0]   src_width;
      logic [SRC_DIM_W-1:0]   src_height;
      logic [DST_W_W-1:0]     dst_width;
      logic [DST_H_W-1:0]     dst_height;
      logic [TEX_SHIFT_W-1:0] tex_shift;   // log2 of texture width, at least 3
   } cfg_type;

   // Morton spread of the low three column bits.
   function automatic logic [5:0] col_spread(input logic [2:0] c);
      logic [5:0] r;
      unique case (c)
         3'd0: r = 6'd0;
         3'd1: r = 6'd1;
         3'd2: r = 6'd4;
         3'd3: r = 6'd5;
         3'd4: r = 6'd16;
         3'd5: r = 6'd17;
         3'd6: r = 6'd20;
         3'd7: r = 6'd21;
         default: r = 6'd0;
      endcase
      return r;
   endfunction

   // Morton spread of the low three row bits.
   function automatic logic [5:0] row_spread(input logic [2:0] c);
      logic [5:0] r;
      unique case (c)
         3'd0: r = 6'd0;
         3'd1: r = 6'd2;
         3'd2: r = 6'd8;
         3'd3: r = 6'd10;
         3'd4: r = 6'd32;
         3'd5: r = 6'd34;
         3'd6: r = 6'd40;
         3'd7: r = 6'd42;
         default: r = 6'd0;
      endcase
      return r;
   endfunction

   // RGBA to ABGR.
   function automatic logic [PIX_W-1:0] swap_bytes(input logic [PIX_W-1:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

// ===== sv/tsta_cfg.sv =====
// Configuration registers with clamping and the derived texture stride shift.
// Depends on tsta_pkg.
`timescale 1ns / 1ps

module tsta_cfg
   import tsta_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [SRC_DIM_W-1:0] csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff, cfg_in;

   // Log2 of the smallest power of two at or above the width, never below 3.
   function automatic logic [TEX_SHIFT_W-1:0] tex_shift_of(input logic [DST_W_W-1:0] w);
      logic [TEX_SHIFT_W-1:0] s;
      s = TEX_SHIFT_W'(DST_W_W);
      for (int p = DST_W_W - 1; p >= 3; p--) begin
         if ((DST_W_W+1)'(1 << p) >= {1'b0, w}) begin
            s = TEX_SHIFT_W'(p);
         end
      end
      return s;
   endfunction

   logic [SRC_DIM_W-1:0] src_dim_clamped;
   logic [DST_W_W-1:0]   dst_w_clamped;
   logic [DST_H_W-1:0]   dst_h_clamped;

   // Clamp each candidate value into its legal range.
   always_comb begin
      src_dim_clamped = csr_wdata;
      if (src_dim_clamped == '0) begin
         src_dim_clamped = SRC_DIM_W'(1);
      end else if (src_dim_clamped > MAX_SRC_DIM) begin
         src_dim_clamped = MAX_SRC_DIM;
      end
      dst_w_clamped = csr_wdata[DST_W_W-1:0];
      if (dst_w_clamped == '0) begin
         dst_w_clamped = DST_W_W'(1);
      end else if (dst_w_clamped > MAX_DST_W) begin
         dst_w_clamped = MAX_DST_W;
      end
      dst_h_clamped = csr_wdata[DST_H_W-1:0];
      if (dst_h_clamped == '0) begin
         dst_h_clamped = DST_H_W'(1);
      end else if (dst_h_clamped > MAX_DST_H) begin
         dst_h_clamped = MAX_DST_H;
      end
   end

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_SRC_WIDTH:  cfg_in.src_width  = src_dim_clamped;
            REG_SRC_HEIGHT: cfg_in.src_height = src_dim_clamped;
            REG_DST_WIDTH: begin
               cfg_in.dst_width = dst_w_clamped;
               cfg_in.tex_shift = tex_shift_of(dst_w_clamped);
            end
            REG_DST_HEIGHT: cfg_in.dst_height = dst_h_clamped;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width  <= SRC_DIM_W'(1);
         cfg_ff.src_height <= SRC_DIM_W'(1);
         cfg_ff.dst_width  <= DST_W_W'(1);
         cfg_ff.dst_height <= DST_H_W'(1);
         cfg_ff.tex_shift  <= TEX_SHIFT_W'(3);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/tsta_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage; house conventions
// from tsta_pkg. The user must hold divisor stable between items; not enforced here.
`timescale 1ns / 1ps

module tsta_div
   import tsta_pkg::*;
#(
   parameter int DVD_W = 21,
   parameter int DVS_W = 9,
   parameter int QUO_W = 12
) (
   input  logic             clock,
   input  logic             en,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic [QUO_W-1:0] quotient
);

   localparam int CW = DVD_W + QUO_W;

   logic [DVD_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   // Stage i settles quotient bit QUO_W-1-i.
   for (genvar i = 0; i < QUO_W; i++) begin : g_stage
      logic [DVD_W-1:0] rem_prev;
      logic [QUO_W-1:0] quo_prev;
      logic [CW-1:0]    trial;
      logic             take;

      if (i == 0) begin : g_first
         assign rem_prev = dividend;
         assign quo_prev = '0;
      end else begin : g_rest
         assign rem_prev = rem_ff[i-1];
         assign quo_prev = quo_ff[i-1];
      end

      assign trial = CW'(divisor) << (QUO_W - 1 - i);
      assign take  = CW'(rem_prev) >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= take ? DVD_W'(CW'(rem_prev) - trial) : rem_prev;
            quo_ff[i] <= quo_prev | (QUO_W'(take) << (QUO_W - 1 - i));
         end
      end
   end

   assign quotient = quo_ff[QUO_W-1];

endmodule

// ===== sv/scaled_texture_tile_addresser.sv =====
// Request beats pass through stage 1, stage 2, the bit-per-stage divider stages for the scaled
// source coordinates and the output register; one beat per cycle sustained when not stalled.
// The whole pipeline stalls together only while the response register holds an untaken beat.
// Synchronous active-high reset clears valid bits; registers reset to 1 (texture width 8).
// Top level; depends on tsta_pkg, tsta_cfg and tsta_div.
`timescale 1ns / 1ps

module scaled_texture_tile_addresser
   import tsta_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // dst_x[8:0], dst_y[16:9], pixel_in[48:17], zero fill above
   input  logic [55:0]          req_tdata,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // src_offset[23:0], tex_offset[40:24], pixel_out[72:41], out_of_range[73], zero fill
   output logic [79:0]          rsp_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [SRC_DIM_W-1:0] csr_wdata
);

   localparam int DIV_STG = SRC_DIM_W;
   localparam int PX_W    = DST_W_W + SRC_DIM_W;
   localparam int PY_W    = DST_H_W + SRC_DIM_W;

   typedef struct packed {
      logic                 oor;
      logic [TEX_OFF_W-1:0] tex;
      logic [PIX_W-1:0]     pix;
   } side_type;

   cfg_type cfg;
   logic    en;

   tsta_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The pipeline moves whenever the response register is free or being drained.
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // Stage 1: capture the request beat.
   logic               v1_ff;
   logic [DST_W_W-1:0] x1_ff;
   logic [DST_H_W-1:0] y1_ff;
   logic [PIX_W-1:0]   pix1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff   <= req_tdata[8:0];
         y1_ff   <= req_tdata[16:9];
         pix1_ff <= req_tdata[48:17];
      end
   end

   // Stage 2: products for the scale, Morton tile offset, range check, byte swap.
   logic                 v2_ff;
   logic [PX_W-1:0]      px2_ff;
   logic [PY_W-1:0]      py2_ff;
   side_type             side2_ff, side2_in;
   logic [TEX_OFF_W-1:0] row_part, col_part;

   always_comb begin
      row_part = TEX_OFF_W'(y1_ff[DST_H_W-1:3]) << (cfg.tex_shift + TEX_SHIFT_W'(3));
      col_part = TEX_OFF_W'(x1_ff[DST_W_W-1:3]) << 6;
      side2_in.oor = (x1_ff >= cfg.dst_width) || (y1_ff >= cfg.dst_height);
      side2_in.tex = row_part + col_part + TEX_OFF_W'(col_spread(x1_ff[2:0]))
                   + TEX_OFF_W'(row_spread(y1_ff[2:0]));
      side2_in.pix = swap_bytes(pix1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px2_ff   <= PX_W'(x1_ff) * PX_W'(cfg.src_width);
         py2_ff   <= PY_W'(y1_ff) * PY_W'(cfg.src_height);
         side2_ff <= side2_in;
      end
   end

   // Division stages: scaled source column and row.
   logic [SRC_DIM_W-1:0] sx, sy;

   tsta_div #(.DVD_W(PX_W), .DVS_W(DST_W_W), .QUO_W(DIV_STG)) u_div_x (
      .clock    (clock),
      .en       (en),
      .dividend (px2_ff),
      .divisor  (cfg.dst_width),
      .quotient (sx)
   );

   tsta_div #(.DVD_W(PY_W), .DVS_W(DST_H_W), .QUO_W(DIV_STG)) u_div_y (
      .clock    (clock),
      .en       (en),
      .dividend (py2_ff),
      .divisor  (cfg.dst_height),
      .quotient (sy)
   );

   // Side data and valid bits travel alongside the dividers.
   logic     vd_ff [DIV_STG];
   side_type sd_ff [DIV_STG];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STG; i++) begin
            vd_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vd_ff[0] <= v2_ff;
         for (int i = 1; i < DIV_STG; i++) begin
            vd_ff[i] <= vd_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sd_ff[0] <= side2_ff;
         for (int i = 1; i < DIV_STG; i++) begin
            sd_ff[i] <= sd_ff[i-1];
         end
      end
   end

   // Output stage: raster source index, zeroing of offsets out of range.
   logic                 rsp_valid_ff;
   logic [SRC_OFF_W-1:0] src_off_ff, src_off_in;
   side_type             out_ff, out_in;
   logic [2*SRC_DIM_W:0] raster;

   always_comb begin
      raster     = (2*SRC_DIM_W+1)'(sy) * (2*SRC_DIM_W+1)'(cfg.src_width)
                 + (2*SRC_DIM_W+1)'(sx);
      out_in     = sd_ff[DIV_STG-1];
      src_off_in = raster[SRC_OFF_W-1:0];
      if (out_in.oor) begin
         src_off_in = '0;
         out_in.tex = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vd_ff[DIV_STG-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         src_off_ff <= src_off_in;
         out_ff     <= out_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, out_ff.oor, out_ff.pix, out_ff.tex, src_off_ff};

endmodule
